@@ src/ffha_pkg.sv @@
// Shared codes, field widths and mark masks of the first-fit heap allocator.
package ffha_pkg;

  // Fixed field widths of the request and result beats
  localparam int OFF_W = 10;
  localparam int REQ_W = 11;
  localparam int ST_W  = 2;
  localparam int MK_W  = 3;

  typedef logic [MK_W-1:0] mark_t;

  // Block header marks
  localparam mark_t MK_FREE = 3'b001;
  localparam mark_t MK_PREV = 3'b010;
  localparam mark_t MK_LAST = 3'b100;

  // Request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  localparam logic [ST_W-1:0] ST_DONE = 2'd0;
  localparam logic [ST_W-1:0] ST_OOM  = 2'd1;
  localparam logic [ST_W-1:0] ST_IGN  = 2'd2;

  // Shared arithmetic unit modes
  localparam logic U_MUL = 1'b0;
  localparam logic U_DIV = 1'b1;

endpackage

@@ src/ffha_unit.sv @@
// Shared arithmetic unit: multiply by the grain plus addend, or divide by the grain.
module ffha_unit #(
  parameter int GRAIN_BYTES = 4,
  parameter int LW          = 13
) (
  input  logic          mode,
  input  logic [LW-1:0] x,
  input  logic [LW-1:0] addend,
  output logic [LW-1:0] y
);
  import ffha_pkg::*;

  localparam int     SH    = LW + 4;
  localparam longint ONE   = 1;
  localparam longint RECIP = ((ONE << SH) + GRAIN_BYTES - 1) / GRAIN_BYTES;
  localparam int     MW    = SH + 1;
  localparam int     PW    = LW + MW;

  logic [MW-1:0] k;
  logic [PW-1:0] prod;

  // Pick the constant: grain for scaling, reciprocal for division
  assign k    = (mode == U_DIV) ? MW'(RECIP) : MW'(GRAIN_BYTES);
  assign prod = PW'(x) * PW'(k);

  // Take the quotient bits or the scaled sum
  assign y = (mode == U_DIV) ? prod[SH +: LW] : (prod[LW-1:0] + addend);

endmodule

@@ src/ffha_store.sv @@
// Block header store: one write port and one registered read port.
module ffha_store #(
  parameter int AW = 8,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem [DEPTH];

  // Write one header record
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/first_fit_heap_allocator.sv @@
// Top level: first-fit heap allocator sequencer around the header store and shared unit.
//
//  channel | direction | handshake          | fields
//  in_     | input     | in_valid/in_stall  | op, request_bytes, free_offset
//  out_    | output    | out_valid/out_stall| block_offset, status
//
// An allocate visits the free list entry by entry; a free walks the physical blocks
// from the pool start. Every header read goes through the store's registered read
// port, and one shared arithmetic unit does every multiply and divide.
// After reset a clearing pass writes every header entry, one per cycle, with in_stall
// high. in_stall is high while an item is worked on; a finished result waits in the
// output register while out_stall holds it.
module first_fit_heap_allocator #(
  parameter int POOL_BYTES   = 1024,
  parameter int HEADER_BYTES = 8,
  parameter int GRAIN_BYTES  = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic [ffha_pkg::REQ_W-1:0]    in_request_bytes,
  input  logic [ffha_pkg::OFF_W-1:0]    in_free_offset,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ffha_pkg::OFF_W-1:0]    out_block_offset,
  output logic [ffha_pkg::ST_W-1:0]     out_status
);
  import ffha_pkg::*;

  localparam int SLOTS       = (POOL_BYTES + GRAIN_BYTES - 1) / GRAIN_BYTES;
  localparam int IW          = $clog2(SLOTS + 1);
  localparam int AW          = $clog2(SLOTS);
  localparam int HSLOT       = (HEADER_BYTES + GRAIN_BYTES - 1) / GRAIN_BYTES;
  localparam int HDR_SPAN    = HSLOT * GRAIN_BYTES;
  localparam int SPLIT_EXTRA = HDR_SPAN + GRAIN_BYTES;
  localparam int LENW        = $clog2(POOL_BYTES + 1);
  localparam int LWA         = $clog2(2 * POOL_BYTES + 2 * GRAIN_BYTES);
  localparam int LW          = (LWA > 12) ? LWA : 12;
  localparam logic [IW-1:0] NIL = IW'(SLOTS);

  typedef struct packed {
    logic [LENW-1:0] len;
    mark_t           mk;
    logic [IW-1:0]   fw;
    logic [IW-1:0]   bw;
  } rec_t;

  typedef struct packed {
    logic            wr;
    logic            set_fw;
    logic [IW-1:0]   fw_v;
    logic            set_bw;
    logic [IW-1:0]   bw_v;
    mark_t           mk_set;
    mark_t           mk_clr;
    logic            len_add;
    logic [LENW-1:0] len_v;
  } rmw_t;

  localparam int RW = $bits(rec_t);

  // Sequencer state codes
  localparam int SW = 6;
  localparam logic [SW-1:0] S_CLR    = 6'd0;
  localparam logic [SW-1:0] S_IDLE   = 6'd1;
  localparam logic [SW-1:0] S_DONE   = 6'd2;
  localparam logic [SW-1:0] S_RD_A   = 6'd3;
  localparam logic [SW-1:0] S_RD_B   = 6'd4;
  localparam logic [SW-1:0] S_NX_MUL = 6'd5;
  localparam logic [SW-1:0] S_NX_DIV = 6'd6;
  localparam logic [SW-1:0] S_A_RND  = 6'd7;
  localparam logic [SW-1:0] S_A_TOT  = 6'd8;
  localparam logic [SW-1:0] S_A_WLK  = 6'd9;
  localparam logic [SW-1:0] S_A_CHK  = 6'd10;
  localparam logic [SW-1:0] S_A_SPL  = 6'd11;
  localparam logic [SW-1:0] S_A_SPW  = 6'd12;
  localparam logic [SW-1:0] S_A_SP1  = 6'd13;
  localparam logic [SW-1:0] S_A_SP2  = 6'd14;
  localparam logic [SW-1:0] S_A_SP3  = 6'd15;
  localparam logic [SW-1:0] S_A_NUPD = 6'd16;
  localparam logic [SW-1:0] S_A_UL1  = 6'd17;
  localparam logic [SW-1:0] S_A_UL2  = 6'd18;
  localparam logic [SW-1:0] S_A_UL3  = 6'd19;
  localparam logic [SW-1:0] S_A_FIN  = 6'd20;
  localparam logic [SW-1:0] S_A_FN2  = 6'd21;
  localparam logic [SW-1:0] S_A_OUT  = 6'd22;
  localparam logic [SW-1:0] S_F_CHK  = 6'd23;
  localparam logic [SW-1:0] S_F_WLK  = 6'd24;
  localparam logic [SW-1:0] S_F_MUL  = 6'd25;
  localparam logic [SW-1:0] S_F_CMP  = 6'd26;
  localparam logic [SW-1:0] S_F_FND  = 6'd27;
  localparam logic [SW-1:0] S_F_HD   = 6'd28;
  localparam logic [SW-1:0] S_F_S1   = 6'd29;
  localparam logic [SW-1:0] S_F_S2   = 6'd30;
  localparam logic [SW-1:0] S_F_U2   = 6'd31;
  localparam logic [SW-1:0] S_F_U3   = 6'd32;
  localparam logic [SW-1:0] S_F_PRV  = 6'd33;
  localparam logic [SW-1:0] S_F_P1   = 6'd34;
  localparam logic [SW-1:0] S_F_P2   = 6'd35;
  localparam logic [SW-1:0] S_F_P3   = 6'd36;
  localparam logic [SW-1:0] S_F_P4   = 6'd37;
  localparam logic [SW-1:0] S_F_P5   = 6'd38;
  localparam logic [SW-1:0] S_F_END  = 6'd39;
  localparam logic [SW-1:0] S_F_E2   = 6'd40;
  localparam logic [SW-1:0] S_F_OK   = 6'd41;

  // Apply a read-modify-write to one header record
  function automatic rec_t apply_mod(input rec_t r, input rmw_t m);
    rec_t o;
    o = r;
    if (m.set_fw) begin
      o.fw = m.fw_v;
    end
    if (m.set_bw) begin
      o.bw = m.bw_v;
    end
    o.mk = (o.mk & ~m.mk_clr) | m.mk_set;
    if (m.len_add) begin
      o.len = o.len + m.len_v;
    end
    return o;
  endfunction

  logic [SW-1:0]    state_r, state_nxt, ret_r, ret_nxt, nret_r, nret_nxt;
  logic [IW-1:0]    ptr_r, ptr_nxt, nb_r, nb_nxt, head_r, head_nxt;
  logic [IW-1:0]    n_r, n_nxt, steps_r, steps_nxt, prev_r, prev_nxt, s_r, s_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  rmw_t             mod_r, mod_nxt;
  rec_t             rec_r, rec_nxt, nrec_r, nrec_nxt, srec_r, srec_nxt;
  logic [LW-1:0]    sum_r, sum_nxt, pos_r, pos_nxt, tslot_r, tslot_nxt, tot_r, tot_nxt;
  logic [REQ_W-1:0] req_r, req_nxt;
  logic [OFF_W-1:0] off_r, off_nxt, res_off_r, res_off_nxt, out_off_r, out_off_nxt;
  logic [ST_W-1:0]  res_st_r, res_st_nxt, out_st_r, out_st_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             we;
  logic [AW-1:0]    wa;
  rec_t             wd;
  logic [RW-1:0]    rdata;
  logic             u_mode;
  logic [LW-1:0]    u_x, u_add, u_y;

  ffha_store #(.AW(AW), .DW(RW)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (wa),
    .wdata (wd),
    .raddr (ptr_r[AW-1:0]),
    .rdata (rdata)
  );

  ffha_unit #(.GRAIN_BYTES(GRAIN_BYTES), .LW(LW)) u_unit (
    .mode   (u_mode),
    .x      (u_x),
    .addend (u_add),
    .y      (u_y)
  );

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_block_offset = out_off_r;
  assign out_status       = out_st_r;

  // Sequencer next-state and datapath
  always_comb begin
    rmw_t m;
    rec_t upd;
    rec_t tmp;
    logic [LW-1:0] sp_w;
    m = '0;
    upd = apply_mod(rec_t'(rdata), mod_r);
    tmp = '0;
    sp_w = LW'(n_r) + tslot_r;
    state_nxt = state_r;  ret_nxt = ret_r;   nret_nxt = nret_r;
    ptr_nxt = ptr_r;      nb_nxt = nb_r;     head_nxt = head_r;
    n_nxt = n_r;          steps_nxt = steps_r; prev_nxt = prev_r;
    s_nxt = s_r;          clr_nxt = clr_r;   mod_nxt = mod_r;
    rec_nxt = rec_r;      nrec_nxt = nrec_r; srec_nxt = srec_r;
    sum_nxt = sum_r;      pos_nxt = pos_r;   tslot_nxt = tslot_r;
    tot_nxt = tot_r;      req_nxt = req_r;   off_nxt = off_r;
    res_off_nxt = res_off_r; res_st_nxt = res_st_r;
    out_off_nxt = out_off_r; out_st_nxt = out_st_r;
    out_valid_nxt = out_valid_r && out_stall;
    u_mode = U_MUL; u_x = '0; u_add = '0;
    we = 1'b0; wa = ptr_r[AW-1:0]; wd = upd;

    case (state_r)
      S_CLR: begin
        we = 1'b1;
        wa = clr_r;
        wd = '0;
        if (clr_r == '0) begin
          wd.len = LENW'(POOL_BYTES);
          wd.mk  = MK_FREE | MK_LAST;
          wd.fw  = NIL;
          wd.bw  = NIL;
        end
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_request_bytes;
          off_nxt = in_free_offset;
          state_nxt = (in_op == OP_FREE) ? S_F_CHK : S_A_RND;
        end
      end
      S_DONE: begin
        // Hold the result until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_off_nxt = res_off_r;
          out_st_nxt = res_st_r;
          state_nxt = S_IDLE;
        end
      end
      S_RD_A: begin
        state_nxt = (ptr_r >= NIL) ? ret_r : S_RD_B;
      end
      S_RD_B: begin
        we = mod_r.wr;
        rec_nxt = upd;
        state_nxt = ret_r;
      end
      S_NX_MUL: begin
        if (ptr_r >= NIL || (rec_r.mk & MK_LAST) != '0) begin
          nb_nxt = NIL;
          state_nxt = nret_r;
        end else begin
          u_x = LW'(ptr_r);
          u_add = LW'(rec_r.len);
          sum_nxt = u_y;
          state_nxt = S_NX_DIV;
        end
      end
      S_NX_DIV: begin
        u_mode = U_DIV;
        u_x = sum_r;
        if (rec_r.len == '0 || sum_r >= LW'(POOL_BYTES)) begin
          nb_nxt = NIL;
        end else begin
          nb_nxt = u_y[IW-1:0];
        end
        state_nxt = nret_r;
      end
      // Allocate: size the block
      S_A_RND: begin
        u_mode = U_DIV;
        u_x = LW'(req_r) + LW'(GRAIN_BYTES - 1);
        tslot_nxt = u_y + LW'(HSLOT);
        state_nxt = S_A_TOT;
      end
      S_A_TOT: begin
        u_x = tslot_r;
        tot_nxt = u_y;
        n_nxt = head_r;
        steps_nxt = '0;
        state_nxt = S_A_WLK;
      end
      // Allocate: walk the free list
      S_A_WLK: begin
        if (n_r >= NIL || steps_r >= NIL) begin
          res_off_nxt = '0;
          res_st_nxt = ST_OOM;
          state_nxt = S_DONE;
        end else begin
          ptr_nxt = n_r;
          mod_nxt = '0;
          ret_nxt = S_A_CHK;
          state_nxt = S_RD_A;
        end
      end
      S_A_CHK: begin
        if ((rec_r.mk & MK_FREE) != '0 && LW'(rec_r.len) >= tot_r) begin
          nrec_nxt = rec_r;
          state_nxt = S_A_SPL;
        end else begin
          n_nxt = rec_r.fw;
          steps_nxt = steps_r + IW'(1);
          state_nxt = S_A_WLK;
        end
      end
      S_A_SPL: begin
        if (LW'(nrec_r.len) >= tot_r + LW'(SPLIT_EXTRA)) begin
          if (sp_w < LW'(SLOTS)) begin
            s_nxt = sp_w[IW-1:0];
            state_nxt = S_A_SPW;
          end else begin
            state_nxt = S_A_NUPD;
          end
        end else begin
          state_nxt = S_A_UL1;
        end
      end
      // Allocate: write the remainder block and find its successor
      S_A_SPW: begin
        tmp.len = LENW'(LW'(nrec_r.len) - tot_r);
        tmp.mk = (nrec_r.mk & MK_LAST) | MK_FREE;
        tmp.fw = nrec_r.fw;
        tmp.bw = nrec_r.bw;
        we = 1'b1;
        wa = s_r[AW-1:0];
        wd = tmp;
        rec_nxt = tmp;
        ptr_nxt = s_r;
        nret_nxt = S_A_SP1;
        state_nxt = S_NX_MUL;
      end
      S_A_SP1: begin
        m.wr = 1'b1; m.set_bw = 1'b1; m.bw_v = s_r;
        mod_nxt = m;
        ptr_nxt = nrec_r.fw;
        ret_nxt = S_A_SP2;
        state_nxt = S_RD_A;
      end
      S_A_SP2: begin
        m.wr = 1'b1; m.set_fw = 1'b1; m.fw_v = s_r;
        mod_nxt = m;
        ptr_nxt = nrec_r.bw;
        ret_nxt = S_A_SP3;
        state_nxt = S_RD_A;
      end
      S_A_SP3: begin
        if (head_r == n_r) begin
          head_nxt = s_r;
        end
        m.wr = 1'b1; m.mk_set = MK_PREV;
        mod_nxt = m;
        ptr_nxt = nb_r;
        ret_nxt = S_A_NUPD;
        state_nxt = S_RD_A;
      end
      S_A_NUPD: begin
        nrec_nxt.len = LENW'(tot_r);
        nrec_nxt.mk = nrec_r.mk & ~MK_LAST;
        state_nxt = S_A_FIN;
      end
      // Allocate: take the whole block off the list
      S_A_UL1: begin
        m.wr = 1'b1; m.set_bw = 1'b1; m.bw_v = nrec_r.bw;
        mod_nxt = m;
        ptr_nxt = nrec_r.fw;
        ret_nxt = S_A_UL2;
        state_nxt = S_RD_A;
      end
      S_A_UL2: begin
        m.wr = 1'b1; m.set_fw = 1'b1; m.fw_v = nrec_r.fw;
        mod_nxt = m;
        ptr_nxt = nrec_r.bw;
        ret_nxt = S_A_UL3;
        state_nxt = S_RD_A;
      end
      S_A_UL3: begin
        if (head_r == n_r) begin
          head_nxt = nrec_r.fw;
        end
        state_nxt = S_A_FIN;
      end
      // Allocate: mark the block used and clear the successor's mark
      S_A_FIN: begin
        tmp = nrec_r;
        tmp.mk = nrec_r.mk & ~MK_FREE;
        we = 1'b1;
        wa = n_r[AW-1:0];
        wd = tmp;
        rec_nxt = tmp;
        ptr_nxt = n_r;
        nret_nxt = S_A_FN2;
        state_nxt = S_NX_MUL;
      end
      S_A_FN2: begin
        m.wr = 1'b1; m.mk_clr = MK_PREV;
        mod_nxt = m;
        ptr_nxt = nb_r;
        ret_nxt = S_A_OUT;
        state_nxt = S_RD_A;
      end
      S_A_OUT: begin
        u_x = LW'(n_r);
        u_add = LW'(HDR_SPAN);
        res_off_nxt = u_y[OFF_W-1:0];
        res_st_nxt = ST_DONE;
        state_nxt = S_DONE;
      end
      // Free: range check
      S_F_CHK: begin
        if (LW'(off_r) < LW'(HDR_SPAN) ||
            (LW'(off_r) - LW'(HDR_SPAN)) >= LW'(POOL_BYTES)) begin
          res_off_nxt = '0;
          res_st_nxt = ST_IGN;
          state_nxt = S_DONE;
        end else begin
          pos_nxt = LW'(off_r) - LW'(HDR_SPAN);
          n_nxt = '0;
          prev_nxt = NIL;
          steps_nxt = '0;
          state_nxt = S_F_WLK;
        end
      end
      // Free: walk the physical chain from the pool start
      S_F_WLK: begin
        if (steps_r >= NIL || n_r >= NIL) begin
          res_off_nxt = '0;
          res_st_nxt = ST_IGN;
          state_nxt = S_DONE;
        end else begin
          ptr_nxt = n_r;
          mod_nxt = '0;
          ret_nxt = S_F_MUL;
          state_nxt = S_RD_A;
        end
      end
      S_F_MUL: begin
        u_x = LW'(n_r);
        u_add = LW'(rec_r.len);
        sum_nxt = u_y;
        state_nxt = S_F_CMP;
      end
      S_F_CMP: begin
        u_mode = U_DIV;
        u_x = sum_r;
        if (sum_r == pos_r + LW'(rec_r.len)) begin
          nrec_nxt = rec_r;
          state_nxt = S_F_FND;
        end else if ((rec_r.mk & MK_LAST) != '0 || rec_r.len == '0 ||
                     sum_r >= LW'(POOL_BYTES)) begin
          res_off_nxt = '0;
          res_st_nxt = ST_IGN;
          state_nxt = S_DONE;
        end else begin
          prev_nxt = n_r;
          n_nxt = u_y[IW-1:0];
          steps_nxt = steps_r + IW'(1);
          state_nxt = S_F_WLK;
        end
      end
      // Free: mark free and push onto the list head
      S_F_FND: begin
        if ((nrec_r.mk & MK_FREE) != '0) begin
          res_off_nxt = '0;
          res_st_nxt = ST_IGN;
          state_nxt = S_DONE;
        end else begin
          tmp = nrec_r;
          tmp.mk = nrec_r.mk | MK_FREE;
          tmp.fw = head_r;
          tmp.bw = NIL;
          we = 1'b1;
          wa = n_r[AW-1:0];
          wd = tmp;
          nrec_nxt = tmp;
          head_nxt = n_r;
          m.wr = 1'b1; m.set_bw = 1'b1; m.bw_v = n_r;
          mod_nxt = m;
          ptr_nxt = head_r;
          ret_nxt = S_F_HD;
          state_nxt = S_RD_A;
        end
      end
      S_F_HD: begin
        rec_nxt = nrec_r;
        ptr_nxt = n_r;
        nret_nxt = S_F_S1;
        state_nxt = S_NX_MUL;
      end
      // Free: merge with a free successor
      S_F_S1: begin
        s_nxt = nb_r;
        ptr_nxt = nb_r;
        mod_nxt = '0;
        ret_nxt = S_F_S2;
        state_nxt = (nb_r < NIL) ? S_RD_A : S_F_PRV;
      end
      S_F_S2: begin
        if ((rec_r.mk & MK_FREE) != '0) begin
          srec_nxt = rec_r;
          m.wr = 1'b1; m.set_bw = 1'b1; m.bw_v = rec_r.bw;
          mod_nxt = m;
          ptr_nxt = rec_r.fw;
          ret_nxt = S_F_U2;
          state_nxt = S_RD_A;
        end else begin
          state_nxt = S_F_PRV;
        end
      end
      S_F_U2: begin
        m.wr = 1'b1; m.set_fw = 1'b1; m.fw_v = srec_r.fw;
        mod_nxt = m;
        ptr_nxt = srec_r.bw;
        ret_nxt = S_F_U3;
        state_nxt = S_RD_A;
      end
      S_F_U3: begin
        if (head_r == s_r) begin
          head_nxt = srec_r.fw;
        end
        m.wr = 1'b1; m.len_add = 1'b1; m.len_v = srec_r.len;
        m.mk_set = srec_r.mk & MK_LAST;
        mod_nxt = m;
        ptr_nxt = n_r;
        ret_nxt = S_F_PRV;
        state_nxt = S_RD_A;
      end
      // Free: merge into a free predecessor
      S_F_PRV: begin
        ptr_nxt = n_r;
        mod_nxt = '0;
        ret_nxt = S_F_P1;
        state_nxt = S_RD_A;
      end
      S_F_P1: begin
        nrec_nxt = rec_r;
        if (prev_r < NIL && (rec_r.mk & MK_PREV) != '0) begin
          ptr_nxt = prev_r;
          mod_nxt = '0;
          ret_nxt = S_F_P2;
          state_nxt = S_RD_A;
        end else begin
          state_nxt = S_F_END;
        end
      end
      S_F_P2: begin
        if ((rec_r.mk & MK_FREE) != '0) begin
          m.wr = 1'b1; m.set_bw = 1'b1; m.bw_v = nrec_r.bw;
          mod_nxt = m;
          ptr_nxt = nrec_r.fw;
          ret_nxt = S_F_P3;
          state_nxt = S_RD_A;
        end else begin
          state_nxt = S_F_END;
        end
      end
      S_F_P3: begin
        m.wr = 1'b1; m.set_fw = 1'b1; m.fw_v = nrec_r.fw;
        mod_nxt = m;
        ptr_nxt = nrec_r.bw;
        ret_nxt = S_F_P4;
        state_nxt = S_RD_A;
      end
      S_F_P4: begin
        if (head_r == n_r) begin
          head_nxt = nrec_r.fw;
        end
        m.wr = 1'b1; m.len_add = 1'b1; m.len_v = nrec_r.len;
        m.mk_set = nrec_r.mk & MK_LAST;
        mod_nxt = m;
        ptr_nxt = prev_r;
        ret_nxt = S_F_P5;
        state_nxt = S_RD_A;
      end
      S_F_P5: begin
        n_nxt = prev_r;
        state_nxt = S_F_END;
      end
      // Free: flag the merged block's successor
      S_F_END: begin
        ptr_nxt = n_r;
        mod_nxt = '0;
        ret_nxt = S_NX_MUL;
        nret_nxt = S_F_E2;
        state_nxt = S_RD_A;
      end
      S_F_E2: begin
        m.wr = 1'b1; m.mk_set = MK_PREV;
        mod_nxt = m;
        ptr_nxt = nb_r;
        ret_nxt = S_F_OK;
        state_nxt = S_RD_A;
      end
      S_F_OK: begin
        res_off_nxt = '0;
        res_st_nxt = ST_DONE;
        state_nxt = S_DONE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    ret_r     <= ret_nxt;    nret_r   <= nret_nxt;  ptr_r    <= ptr_nxt;
    nb_r      <= nb_nxt;     n_r      <= n_nxt;     steps_r  <= steps_nxt;
    prev_r    <= prev_nxt;   s_r      <= s_nxt;     mod_r    <= mod_nxt;
    rec_r     <= rec_nxt;    nrec_r   <= nrec_nxt;  srec_r   <= srec_nxt;
    sum_r     <= sum_nxt;    pos_r    <= pos_nxt;   tslot_r  <= tslot_nxt;
    tot_r     <= tot_nxt;    req_r    <= req_nxt;   off_r    <= off_nxt;
    res_off_r <= res_off_nxt; res_st_r <= res_st_nxt;
    out_off_r <= out_off_nxt; out_st_r <= out_st_nxt;
  end

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted beat did not start work");

  a_fail_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_DONE) |-> (out_block_offset == '0))
    else $error("failed request carries a nonzero offset");

  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> in_stall)
    else $error("input taken during clearing pass");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= NIL)
    else $error("list head out of range");

  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid && out_stall) |=> (state_r == S_DONE))
    else $error("result overwrote a stalled beat");
`endif

endmodule
